// ----- rtl/min_coin_change_dp_assert.svh -----
`ifndef MIN_COIN_CHANGE_DP_ASSERT_SVH
`define MIN_COIN_CHANGE_DP_ASSERT_SVH

// check that holds in the same cycle as its condition
`define MCCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that holds in the cycle after its condition
`define MCCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mccd_pkg.sv -----
package mccd_pkg;

    localparam int MAX_AMOUNT  = 1023;
    localparam int COIN_TYPES  = 5;
    localparam int ROW_LEN     = MAX_AMOUNT + 1;
    localparam int TABLE_DEPTH = COIN_TYPES * ROW_LEN;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COL_W       = $clog2(ROW_LEN);
    localparam int ROW_W       = (COIN_TYPES > 1) ? $clog2(COIN_TYPES) : 1;

    // fixed field widths
    localparam int AMOUNT_W    = 10;
    localparam int VAL_W       = 10;
    localparam int TYPES_W     = 3;
    localparam int INDEX_W     = 3;
    localparam int COUNT_OUT_W = 10;
    localparam int CNT_W       = 11;

    localparam logic [CNT_W-1:0] INF_COUNT = '1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE0 = 3'd1;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [VAL_W-1:0]   t_val;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef struct packed {
        logic took;
        t_cnt count;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    localparam logic [TYPES_W-1:0] RESET_TYPES = 3'd5;
    localparam t_val RESET_VALUES [COIN_TYPES] = '{10'd1, 10'd2, 10'd5, 10'd6, 10'd10};

    function automatic t_addr cell_addr(input t_row row, input t_col col);
        return ADDR_W'(int'(row) * ROW_LEN + int'(col));
    endfunction

    function automatic t_cnt sat_inc(input t_cnt c);
        return (c == INF_COUNT) ? INF_COUNT : c + t_cnt'(1);
    endfunction

endpackage

// ----- rtl/mccd_in_if.sv -----
interface mccd_in_if;
    logic                              valid;
    logic                              ready;
    logic [mccd_pkg::AMOUNT_W-1:0]     amount;

    modport source (output valid, output amount, input ready);
    modport sink   (input valid, input amount, output ready);
endinterface

// ----- rtl/mccd_out_if.sv -----
interface mccd_out_if;
    logic                               valid;
    logic                               ready;
    logic [mccd_pkg::INDEX_W-1:0]       coin_index;
    logic [mccd_pkg::VAL_W-1:0]         coin_value;
    logic [mccd_pkg::COUNT_OUT_W-1:0]   coin_count;
    logic                               unreachable;
    logic                               last;

    modport source (output valid, output coin_index, output coin_value, output coin_count,
                    output unreachable, output last, input ready);
    modport sink   (input valid, input coin_index, input coin_value, input coin_count,
                    input unreachable, input last, output ready);
endinterface

// ----- rtl/mccd_ram.sv -----
module mccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_a,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/min_coin_change_dp.sv -----
// operation: table fill over n rows of amount+1 cells, then a backtrack unless the amount is 0 or unreachable,
// then n results, one per cycle while the sink is ready (n = active coin types, 1 to 5)
// throughput: one item at a time, a new amount is accepted only in idle;
// each table cell takes a read state (S_FRD) and a write state (S_FWR) on the single table memory
// reset: synchronous active low; coin types back to 5, values to 1 2 5 6 10, block idle
module min_coin_change_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mccd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mccd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mccd_in_if.sink                             i_in,
    mccd_out_if.source                          o_out
);

`include "min_coin_change_dp_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FRD  = 3'd1;
    localparam logic [2:0] S_FWR  = 3'd2;
    localparam logic [2:0] S_BRD  = 3'd3;
    localparam logic [2:0] S_BEV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]                           r_state;
    logic [mccd_pkg::TYPES_W-1:0]         r_types;
    mccd_pkg::t_val                       r_coin_value [mccd_pkg::COIN_TYPES];
    mccd_pkg::t_col                       r_counts [mccd_pkg::COIN_TYPES];
    mccd_pkg::t_row                       r_row;
    mccd_pkg::t_row                       r_last_row;
    mccd_pkg::t_col                       r_col;
    mccd_pkg::t_col                       r_amount;
    logic                                 r_unreach;

    mccd_pkg::t_val                       w_coin;
    logic                                 w_usable;
    mccd_pkg::t_col                       w_bcol;
    mccd_pkg::t_col                       w_amount;
    mccd_pkg::t_row                       w_last_row;
    mccd_pkg::t_cell                      w_above;
    mccd_pkg::t_cell                      w_back;
    mccd_pkg::t_cell                      w_new;
    mccd_pkg::t_cnt                       w_with;
    mccd_pkg::t_col                       w_bt_col;
    mccd_pkg::t_addr                      w_raddr_a;
    mccd_pkg::t_addr                      w_raddr_b;
    logic [mccd_pkg::CELL_W-1:0]          w_rdata_a;
    logic [mccd_pkg::CELL_W-1:0]          w_rdata_b;
    logic                                 w_out_fire;
    logic                                 w_in_fire;

    // coin of the current row
    assign w_coin   = r_coin_value[r_row];
    assign w_usable = (w_coin != '0) && (int'(r_col) >= int'(w_coin));
    assign w_bcol   = w_usable ? mccd_pkg::COL_W'(int'(r_col) - int'(w_coin)) : r_col;
    assign w_bt_col = (int'(w_coin) <= int'(r_col))
                    ? mccd_pkg::COL_W'(int'(r_col) - int'(w_coin)) : '0;

    assign w_amount = (int'(i_in.amount) > mccd_pkg::MAX_AMOUNT)
                    ? mccd_pkg::COL_W'(mccd_pkg::MAX_AMOUNT)
                    : mccd_pkg::COL_W'(i_in.amount);

    always_comb begin
        if (r_types == '0) begin
            w_last_row = '0;
        end else if (int'(r_types) > mccd_pkg::COIN_TYPES) begin
            w_last_row = mccd_pkg::ROW_W'(mccd_pkg::COIN_TYPES - 1);
        end else begin
            w_last_row = mccd_pkg::ROW_W'(int'(r_types) - 1);
        end
    end

    // fill reads the row above and the same row one coin back
    always_comb begin
        if (r_state == S_FRD) begin
            w_raddr_a = mccd_pkg::cell_addr((r_row == '0) ? r_row : r_row - 1'b1, r_col);
        end else begin
            w_raddr_a = mccd_pkg::cell_addr(r_row, r_col);
        end
        w_raddr_b = mccd_pkg::cell_addr(r_row, w_bcol);
    end

    assign w_above = mccd_pkg::t_cell'(w_rdata_a);
    assign w_back  = mccd_pkg::t_cell'(w_rdata_b);
    assign w_with  = mccd_pkg::sat_inc(w_back.count);

    always_comb begin
        priority if (r_col == '0) begin
            w_new.count = '0;
            w_new.took  = 1'b0;
        end else if (r_row == '0) begin
            w_new.count = w_usable ? w_with : mccd_pkg::INF_COUNT;
            w_new.took  = w_usable;
        end else if (!w_usable) begin
            w_new.count = w_above.count;
            w_new.took  = 1'b0;
        end else begin
            w_new.took  = (w_with < w_above.count);
            w_new.count = w_new.took ? w_with : w_above.count;
        end
    end

    mccd_ram #(
        .WIDTH (mccd_pkg::CELL_W),
        .DEPTH (mccd_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (r_state == S_FWR),
        .i_waddr   (mccd_pkg::cell_addr(r_row, r_col)),
        .i_wdata   (w_new),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_types <= mccd_pkg::RESET_TYPES;
            for (int k = 0; k < mccd_pkg::COIN_TYPES; k++) begin
                r_coin_value[k] <= mccd_pkg::RESET_VALUES[k];
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mccd_pkg::CFG_TYPES) begin
                    r_types <= i_cfg_data[mccd_pkg::TYPES_W-1:0];
                end
                for (int k = 0; k < mccd_pkg::COIN_TYPES; k++) begin
                    if (int'(i_cfg_idx) == int'(mccd_pkg::CFG_VALUE0) + k) begin
                        r_coin_value[k] <= i_cfg_data[mccd_pkg::VAL_W-1:0];
                    end
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    if (r_col != r_amount) begin
                        r_state <= S_FRD;
                    end else if (r_row != r_last_row) begin
                        r_state <= S_FRD;
                    end else if (w_new.count == mccd_pkg::INF_COUNT || r_col == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_BRD;
                    end
                end
                S_BRD: begin
                    r_state <= S_BEV;
                end
                S_BEV: begin
                    if (!w_above.took) begin
                        r_state <= (r_row == '0) ? S_EMIT : S_BRD;
                    end else begin
                        r_state <= (w_bt_col == '0) ? S_EMIT : S_BRD;
                    end
                end
                S_EMIT: begin
                    if (w_out_fire && r_row == r_last_row) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_amount   <= w_amount;
                    r_last_row <= w_last_row;
                    r_row      <= '0;
                    r_col      <= '0;
                    for (int k = 0; k < mccd_pkg::COIN_TYPES; k++) begin
                        r_counts[k] <= '0;
                    end
                end
            end
            S_FWR: begin
                if (r_col != r_amount) begin
                    r_col <= r_col + 1'b1;
                end else if (r_row != r_last_row) begin
                    r_row <= r_row + 1'b1;
                    r_col <= '0;
                end else begin
                    // last cell is the full answer
                    r_unreach <= (w_new.count == mccd_pkg::INF_COUNT);
                    if (w_new.count == mccd_pkg::INF_COUNT || r_col == '0) begin
                        r_row <= '0;
                    end
                end
            end
            S_BEV: begin
                if (!w_above.took) begin
                    if (r_row != '0) begin
                        r_row <= r_row - 1'b1;
                    end
                end else begin
                    r_counts[r_row] <= r_counts[r_row] + 1'b1;
                    r_col <= w_bt_col;
                    if (w_bt_col == '0) begin
                        r_row <= '0;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_fire && r_row != r_last_row) begin
                    r_row <= r_row + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_EMIT);
    assign o_out.coin_index  = mccd_pkg::INDEX_W'(r_row);
    assign o_out.coin_value  = w_coin;
    assign o_out.coin_count  = r_unreach ? '0 : mccd_pkg::COUNT_OUT_W'(r_counts[r_row]);
    assign o_out.unreachable = r_unreach;
    assign o_out.last        = (r_row == r_last_row);

    `MCCD_ASSERT_SAME(a_idle_no_result, i_in.ready, !o_out.valid, "result shown while idle")
    `MCCD_ASSERT_SAME(a_unreach_zero, o_out.valid && o_out.unreachable,
                      o_out.coin_count == '0, "unreachable result with nonzero count")
    `MCCD_ASSERT_NEXT(a_last_to_idle, o_out.valid && o_out.ready && o_out.last,
                      i_in.ready, "not idle after last result")
    `MCCD_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready,
                      !i_in.ready, "ready right after accepting an item")

endmodule
